// File: rtl/mavps_pkg.sv
package mavps_pkg;

	// window geometry
	localparam int WINDOW_LEN = 900;
	localparam int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

	// field widths
	localparam int SAMPLE_W = 18;
	localparam int PEAK_W   = 17;
	localparam int MARGIN_W = 16;
	localparam int HYST_W   = 16;
	localparam int THR_W    = 20;

	// running sum holds WINDOW_LEN signed samples
	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int ITER_W = $clog2(SUM_W);

	// constants
	localparam logic [PEAK_W-1:0]   MIN_PEAK_W       = PEAK_W'(2500);
	localparam logic [PEAK_W-1:0]   RST_MONTHLY_PEAK = PEAK_W'(2500);
	localparam logic [MARGIN_W-1:0] RST_BUFFER       = MARGIN_W'(100);
	localparam logic [HYST_W-1:0]   RST_HYST         = HYST_W'(50);

	// item commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// register map
	typedef enum logic [1:0] {
		REG_MONTHLY_PEAK  = 2'd0,
		REG_BUFFER_MARGIN = 2'd1,
		REG_HYSTERESIS    = 2'd2
	} reg_idx_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// File: rtl/mavps_div.sv
module mavps_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mavps_pkg::SUM_W-1:0]  dividend,
	input  logic [mavps_pkg::CNT_W-1:0]  divisor,
	output mavps_pkg::div_status_t       status,
	output logic [mavps_pkg::SUM_W-1:0]  quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [mavps_pkg::ITER_W-1:0]  iter_q;
	logic [mavps_pkg::CNT_W-1:0]   rem_q;
	logic [mavps_pkg::SUM_W-1:0]   dq_q;
	logic [mavps_pkg::CNT_W-1:0]   dvs_q;

	logic [mavps_pkg::CNT_W:0]     trial;
	logic [mavps_pkg::CNT_W:0]     diff;
	logic                          ge;

	// restoring step, one quotient bit a cycle
	always_comb begin
		trial = {rem_q, dq_q[mavps_pkg::SUM_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= mavps_pkg::ITER_W'(mavps_pkg::SUM_W - 1);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[mavps_pkg::CNT_W-1:0] : trial[mavps_pkg::CNT_W-1:0];
			dq_q  <= {dq_q[mavps_pkg::SUM_W-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = dq_q;

endmodule

// File: rtl/moving_average_peak_shedder.sv
// moving average peak shedder: takes one request at a time, either a signed power
// sample or a clear. a sample is handled in steps: accept and read the
// oldest sample from the single-port ring memory, update the running sum and
// write the new sample back, form sum / fill count in the serial divider, then
// evaluate the shed threshold and hand the result to the output register. a clear
// empties the window and goes to the output step. the output register lets the
// next request be taken while a result still waits on out_stall. the ring memory
// needs no clearing after reset: a value read is only used once the window is full.
// configuration is an apb-style port, registers at byte addresses 0, 4 and 8
// (monthly peak, buffer margin, hysteresis); write only while the block is idle.
module moving_average_peak_shedder (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic signed [mavps_pkg::SAMPLE_W-1:0] sample_w,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [mavps_pkg::SAMPLE_W-1:0] window_average,
	output logic                                relay_on,
	output logic                                state_changed,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration registers
	logic [mavps_pkg::PEAK_W-1:0]   monthly_peak_q;
	logic [mavps_pkg::MARGIN_W-1:0] buffer_margin_q;
	logic [mavps_pkg::HYST_W-1:0]   hysteresis_q;

	// window state
	logic [mavps_pkg::PTR_W-1:0]          wp_q;
	logic [mavps_pkg::CNT_W-1:0]          fill_q;
	logic signed [mavps_pkg::SUM_W-1:0]   sum_q;
	logic signed [mavps_pkg::SAMPLE_W-1:0] avg_q;
	logic                                 shed_q;
	logic                                 chg_q;

	// request in flight
	logic signed [mavps_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                 full_s1;
	logic                                 neg_q;

	// output register
	logic                                 out_valid_q;
	logic signed [mavps_pkg::SAMPLE_W-1:0] out_avg_q;
	logic                                 out_relay_q;
	logic                                 out_chg_q;

	// ring memory
	logic signed [mavps_pkg::SAMPLE_W-1:0] ring [mavps_pkg::WINDOW_LEN];
	logic signed [mavps_pkg::SAMPLE_W-1:0] rd_q;
	logic                                 mem_re;
	logic                                 mem_we;

	logic                                 in_acc;
	logic                                 cfg_wr;
	logic                                 out_free;

	logic signed [mavps_pkg::SUM_W:0]     old_ext;
	logic signed [mavps_pkg::SUM_W:0]     new_ext;
	logic signed [mavps_pkg::SUM_W:0]     nsum_wide;
	logic signed [mavps_pkg::SUM_W-1:0]   nsum;
	logic [mavps_pkg::SUM_W-1:0]          nsum_mag;
	logic [mavps_pkg::CNT_W-1:0]          nfill;
	logic                                 last_slot;

	mavps_pkg::div_status_t               div_st;
	logic [mavps_pkg::SUM_W-1:0]          div_q;
	logic [mavps_pkg::SUM_W-1:0]          avg_full;
	logic signed [mavps_pkg::SAMPLE_W-1:0] avg_new;

	logic [mavps_pkg::PEAK_W-1:0]         peak_eff;
	logic signed [mavps_pkg::THR_W-1:0]   thr;
	logic signed [mavps_pkg::THR_W-1:0]   thr_low;
	logic signed [mavps_pkg::THR_W-1:0]   avg_ext;
	logic                                 go_shed;
	logic                                 go_restore;

	// handshakes
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	// ring access: read the oldest slot on accept, write the new sample back in
	// ST_READ; one request at a time so a read never meets a pending write
	assign mem_re = in_acc && (cmd == mavps_pkg::CMD_SAMPLE);
	assign mem_we = (state_q == ST_READ);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring[wp_q] <= sample_s1;
		end
		if (mem_re) begin
			rd_q <= ring[wp_q];
		end
	end

	// sum update; the oldest sample only leaves a full window
	always_comb begin
		old_ext   = full_s1 ? (mavps_pkg::SUM_W+1)'(rd_q) : '0;
		new_ext   = (mavps_pkg::SUM_W+1)'(sample_s1);
		nsum_wide = (mavps_pkg::SUM_W+1)'(sum_q) + new_ext - old_ext;
		nsum      = nsum_wide[mavps_pkg::SUM_W-1:0];
		nsum_mag  = nsum[mavps_pkg::SUM_W-1] ? (-nsum) : nsum;
		nfill     = full_s1 ? fill_q : (fill_q + 1'b1);
		last_slot = (wp_q == mavps_pkg::PTR_W'(mavps_pkg::WINDOW_LEN - 1));
	end

	mavps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mem_we),
		.dividend (nsum_mag),
		.divisor  (nfill),
		.status   (div_st),
		.quotient (div_q)
	);

	// signed quotient truncated toward zero; it always fits a sample
	always_comb begin
		avg_full = neg_q ? (-div_q) : div_q;
		avg_new  = avg_full[mavps_pkg::SAMPLE_W-1:0];
	end

	// threshold with hysteresis, exact signed compare
	always_comb begin
		peak_eff   = (monthly_peak_q < mavps_pkg::MIN_PEAK_W) ? mavps_pkg::MIN_PEAK_W
		                                                     : monthly_peak_q;
		thr        = mavps_pkg::THR_W'(peak_eff) + mavps_pkg::THR_W'(buffer_margin_q);
		thr_low    = thr - mavps_pkg::THR_W'(hysteresis_q);
		avg_ext    = mavps_pkg::THR_W'(avg_new);
		go_shed    = !shed_q && (avg_ext >= thr);
		go_restore = shed_q && (avg_ext < thr_low);
	end

	// sequencer with window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			shed_q      <= 1'b0;
			chg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (cmd == mavps_pkg::CMD_CLEAR) begin
							// empty the window, keep the last average
							chg_q   <= shed_q;
							shed_q  <= 1'b0;
							wp_q    <= '0;
							fill_q  <= '0;
							sum_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					sum_q   <= nsum;
					fill_q  <= nfill;
					wp_q    <= last_slot ? '0 : (wp_q + 1'b1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_st.done) begin
						avg_q   <= avg_new;
						chg_q   <= go_shed || go_restore;
						if (go_shed) begin
							shed_q <= 1'b1;
						end else if (go_restore) begin
							shed_q <= 1'b0;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= sample_w;
			full_s1   <= (fill_q == mavps_pkg::CNT_W'(mavps_pkg::WINDOW_LEN));
		end
		if (mem_we) begin
			neg_q <= nsum[mavps_pkg::SUM_W-1];
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_avg_q   <= avg_q;
			out_relay_q <= !shed_q;
			out_chg_q   <= chg_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign window_average = out_avg_q;
	assign relay_on       = out_relay_q;
	assign state_changed  = out_chg_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monthly_peak_q  <= mavps_pkg::RST_MONTHLY_PEAK;
			buffer_margin_q <= mavps_pkg::RST_BUFFER;
			hysteresis_q    <= mavps_pkg::RST_HYST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mavps_pkg::REG_MONTHLY_PEAK:  monthly_peak_q  <= pwdata[mavps_pkg::PEAK_W-1:0];
				mavps_pkg::REG_BUFFER_MARGIN: buffer_margin_q <= pwdata[mavps_pkg::MARGIN_W-1:0];
				mavps_pkg::REG_HYSTERESIS:    hysteresis_q    <= pwdata[mavps_pkg::HYST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			mavps_pkg::REG_MONTHLY_PEAK:  prdata = 32'(monthly_peak_q);
			mavps_pkg::REG_BUFFER_MARGIN: prdata = 32'(buffer_margin_q);
			mavps_pkg::REG_HYSTERESIS:    prdata = 32'(hysteresis_q);
			default:                      prdata = '0;
		endcase
	end

	// fill count never passes the window length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mavps_pkg::CNT_W'(mavps_pkg::WINDOW_LEN))
		else $error("fill count beyond window length");

	// a clear empties the window and ends shedding
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd == mavps_pkg::CMD_CLEAR)) |=> (fill_q == '0) && !shed_q && (wp_q == '0))
		else $error("clear did not empty the window");

	// the divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIV) && !div_st.busy)
		else $error("divider result outside the divide phase");

	// a waiting result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q && $stable(out_avg_q) && $stable(out_chg_q))
		else $error("pending result lost");

endmodule
